// ===== hw/rtl/scl_pkg.sv =====
// Shared types and constants for the shell command lexer.
// Holds the token kind codes, character codes and the request entry types.
// No dependencies.
package scl_pkg;

   localparam logic [3:0] KIND_NAME_BYTE = 4'd0;
   localparam logic [3:0] KIND_NAME_END  = 4'd1;
   localparam logic [3:0] KIND_PIPE      = 4'd2;
   localparam logic [3:0] KIND_AMP       = 4'd3;
   localparam logic [3:0] KIND_LT        = 4'd4;
   localparam logic [3:0] KIND_GT        = 4'd5;
   localparam logic [3:0] KIND_APPEND    = 4'd6;
   localparam logic [3:0] KIND_SEMI      = 4'd7;
   localparam logic [3:0] KIND_EOF       = 4'd8;

   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_EOL  = 1'b1;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] text;
   } tok_type;

   typedef struct packed {
      tok_type tok0;
      tok_type tok1;
      logic    two;
   } entry_type;

endpackage

// ===== hw/rtl/shell_command_lexer.sv =====
// Top level of the shell command lexer: front end, entry queue and back end.
// Depends on scl_pkg, scl_front, scl_queue and scl_back.
//
//   Channel    Ports                                     Handshake
//   request    req_opcode, req_char_byte                 push / full
//   result     rsp_token_kind, rsp_text_byte,            pop / empty
//              rsp_last_of_run
//
// A request is taken every cycle while the entry queue has room; the front end
// classifies it in that same cycle and queues its one or two tokens.
// The back end delivers one token per cycle while pop is held; a request that makes
// two tokens keeps its second in a pending register until the first is popped.
// A request's first token passes through the entry queue, then the output register.
// Reset is synchronous and clears the lexer mode, the queue and the output and pending valid flags.
module shell_command_lexer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_opcode,
   input  logic [7:0] req_char_byte,
   output logic       empty,
   input  logic       pop,
   output logic [3:0] rsp_token_kind,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_last_of_run
);
   import scl_pkg::*;

   logic      accept;
   logic      wr_en;
   entry_type wr_entry;
   entry_type rd_entry;
   logic      q_rd, q_full, q_empty;

   assign full = q_full;
   assign accept = push && !q_full;

   scl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .eol       (req_opcode == OP_EOL),
      .char_byte (req_char_byte),
      .wr_en     (wr_en),
      .wr_entry  (wr_entry)
   );

   scl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .rd_en    (q_rd),
      .rd_entry (rd_entry),
      .full     (q_full),
      .empty    (q_empty)
   );

   scl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_entry     (rd_entry),
      .q_rd        (q_rd),
      .pop         (pop),
      .empty       (empty),
      .token_kind  (rsp_token_kind),
      .text_byte   (rsp_text_byte),
      .last_of_run (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   a_text_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind != KIND_NAME_BYTE) |-> rsp_text_byte == 8'd0)
      else $error("text byte not zero on a non-name token");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind == KIND_EOF) |-> rsp_last_of_run)
      else $error("end-of-file token not marked last");

   a_eol_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_EOL) |=> (!q_empty || !empty))
      else $error("end-of-line request produced no pending token");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty at once");
`endif

endmodule

// ===== hw/rtl/scl_front.sv =====
// Front end of the shell command lexer: accepts requests, tracks the lexer mode
// and turns each request into at most one entry of one or two tokens.
// Depends on scl_pkg.
module scl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              eol,
   input  logic [7:0]        char_byte,
   output logic              wr_en,
   output scl_pkg::entry_type wr_entry
);
   import scl_pkg::*;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_NAME  = 2'd1;
   localparam logic [1:0] MODE_QUOTE = 2'd2;
   localparam logic [1:0] MODE_GT    = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic       set_quote;
      logic       quote_single;
      logic       emit;
      tok_type    tok;
   } idle_res_type;

   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
   endfunction

   function automatic logic [3:0] op_kind(input logic [7:0] b);
      unique case (b)
         CH_PIPE: op_kind = KIND_PIPE;
         CH_AMP:  op_kind = KIND_AMP;
         CH_LT:   op_kind = KIND_LT;
         CH_GT:   op_kind = KIND_GT;
         CH_SEMI: op_kind = KIND_SEMI;
         default: op_kind = KIND_NAME_BYTE;
      endcase
   endfunction

   function automatic idle_res_type idle_step(input logic [7:0] b);
      idle_res_type r;
      logic [3:0]   k;
      k = op_kind(b);
      r = '0;
      r.mode = MODE_IDLE;
      if (is_blank(b)) begin
         r.mode = MODE_IDLE;
      end else if (k == KIND_GT) begin
         r.mode = MODE_GT;
      end else if (k != KIND_NAME_BYTE) begin
         r.emit = 1'b1;
         r.tok.kind = k;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         r.mode = MODE_QUOTE;
         r.set_quote = 1'b1;
         r.quote_single = (b == CH_SQUOTE);
      end else begin
         r.mode = MODE_NAME;
         r.emit = 1'b1;
         r.tok.kind = KIND_NAME_BYTE;
         r.tok.text = b;
      end
      return r;
   endfunction

   logic [1:0]   mode_ff, mode_in;
   logic         qsingle_ff, qsingle_in;
   idle_res_type idle_r;
   tok_type      t0, t1;
   logic         have_one, have_two;
   logic [7:0]   close_quote;

   always_comb begin
      idle_r = idle_step(char_byte);
      close_quote = qsingle_ff ? CH_SQUOTE : CH_DQUOTE;
      mode_in = mode_ff;
      qsingle_in = qsingle_ff;
      t0 = '0;
      t1 = '0;
      have_one = 1'b0;
      have_two = 1'b0;
      if (eol) begin
         mode_in = MODE_IDLE;
         have_one = 1'b1;
         if (mode_ff == MODE_NAME || mode_ff == MODE_QUOTE) begin
            t0.kind = KIND_NAME_END;
            t1.kind = KIND_EOF;
            have_two = 1'b1;
         end else if (mode_ff == MODE_GT) begin
            t0.kind = KIND_GT;
            t1.kind = KIND_EOF;
            have_two = 1'b1;
         end else begin
            t0.kind = KIND_EOF;
         end
      end else begin
         unique case (mode_ff)
            MODE_IDLE: begin
               mode_in = idle_r.mode;
               if (idle_r.set_quote) begin
                  qsingle_in = idle_r.quote_single;
               end
               have_one = idle_r.emit;
               t0 = idle_r.tok;
            end
            MODE_NAME: begin
               have_one = 1'b1;
               if (is_blank(char_byte) || op_kind(char_byte) != KIND_NAME_BYTE) begin
                  t0.kind = KIND_NAME_END;
                  mode_in = idle_r.mode;
                  have_two = idle_r.emit;
                  t1 = idle_r.tok;
               end else begin
                  t0.kind = KIND_NAME_BYTE;
                  t0.text = char_byte;
               end
            end
            MODE_QUOTE: begin
               have_one = 1'b1;
               if (char_byte == close_quote) begin
                  t0.kind = KIND_NAME_END;
                  mode_in = MODE_IDLE;
               end else begin
                  t0.kind = KIND_NAME_BYTE;
                  t0.text = char_byte;
               end
            end
            MODE_GT: begin
               have_one = 1'b1;
               if (char_byte == CH_GT) begin
                  t0.kind = KIND_APPEND;
                  mode_in = MODE_IDLE;
               end else begin
                  t0.kind = KIND_GT;
                  mode_in = idle_r.mode;
                  if (idle_r.set_quote) begin
                     qsingle_in = idle_r.quote_single;
                  end
                  have_two = idle_r.emit;
                  t1 = idle_r.tok;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
      wr_en = accept && have_one;
      wr_entry.tok0 = t0;
      wr_entry.tok1 = t1;
      wr_entry.two = have_two;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         qsingle_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         qsingle_ff <= qsingle_in;
      end
   end

endmodule

// ===== hw/rtl/scl_queue.sv =====
// Short queue of token entries between the front and back ends.
// Depends on scl_pkg.
module scl_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  scl_pkg::entry_type wr_entry,
   input  logic               rd_en,
   output scl_pkg::entry_type rd_entry,
   output logic               full,
   output logic               empty
);
   import scl_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   entry_type       mem [DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_entry = mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/scl_back.sv =====
// Back end of the shell command lexer: splits queued entries into single
// tokens and holds the oldest one in an output register until it is popped.
// Depends on scl_pkg.
module scl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  scl_pkg::entry_type q_entry,
   output logic               q_rd,
   input  logic               pop,
   output logic               empty,
   output logic [3:0]         token_kind,
   output logic [7:0]         text_byte,
   output logic               last_of_run
);
   import scl_pkg::*;

   logic    slot_valid_ff, slot_valid_in;
   tok_type slot_ff, slot_in;
   logic    slot_last_ff, slot_last_in;
   logic    pend_valid_ff, pend_valid_in;
   tok_type pend_ff, pend_in;
   logic    take;

   assign take = !slot_valid_ff || pop;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_in = slot_ff;
      slot_last_in = slot_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      q_rd = 1'b0;
      if (take) begin
         if (pend_valid_ff) begin
            slot_valid_in = 1'b1;
            slot_in = pend_ff;
            slot_last_in = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!q_empty) begin
            q_rd = 1'b1;
            slot_valid_in = 1'b1;
            slot_in = q_entry.tok0;
            slot_last_in = !q_entry.two;
            pend_valid_in = q_entry.two;
            pend_in = q_entry.tok1;
         end else begin
            slot_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      slot_last_ff <= slot_last_in;
      pend_ff <= pend_in;
   end

   assign empty = !slot_valid_ff;
   assign token_kind = slot_ff.kind;
   assign text_byte = slot_ff.text;
   assign last_of_run = slot_last_ff;

endmodule

// ===== verif/shell_command_lexer_test.sv =====
// Self-checking testbench for shell_command_lexer: directed table, then random lines and bytes.
// Expected tokens come from the table rows, then from a behavioral lexer in this file; all are checked in order.
// Depends on scl_pkg and the shell_command_lexer RTL.
module shell_command_lexer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import scl_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEM_TARGET = 1850;
   localparam int HOLD_CYCLES = 300;

   typedef enum logic [1:0] {LEX_IDLE, LEX_NAME, LEX_QUOTE, LEX_GT} lex_mode_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] text;
      logic       last;
   } lex_token_type;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
      logic       fixed;
      logic [1:0] count;
      logic [3:0] k0;
      logic [7:0] x0;
      logic [3:0] k1;
      logic [7:0] x1;
   } lex_row_type;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic       req_opcode;
   logic [7:0] req_char_byte;
   logic       empty;
   logic       pop;
   logic [3:0] rsp_token_kind;
   logic [7:0] rsp_text_byte;
   logic       rsp_last_of_run;

   lex_mode_type  lex_mode = LEX_IDLE;
   logic          quote_single = 1'b0;
   lex_token_type step_tokens[$];
   lex_token_type pending_tokens[$];

   lex_row_type   directed_rows [0:25];
   lex_row_type   fixed_row;
   logic          fixed_on = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int items_sent = 0;
   int items_accepted = 0;
   int eol_accepted = 0;
   int tokens_seen = 0;
   int operators_seen = 0;
   int fail_count = 0;

   shell_command_lexer dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_opcode(req_opcode),
      .req_char_byte(req_char_byte),
      .empty(empty),
      .pop(pop),
      .rsp_token_kind(rsp_token_kind),
      .rsp_text_byte(rsp_text_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   function automatic logic is_blank(logic [7:0] b);
      return (b >= 8'd9 && b <= 8'd13) || b == CH_SPACE;
   endfunction

   function automatic logic [3:0] op_kind(logic [7:0] b);
      case (b)
         CH_PIPE: return KIND_PIPE;
         CH_AMP:  return KIND_AMP;
         CH_LT:   return KIND_LT;
         CH_GT:   return KIND_GT;
         CH_SEMI: return KIND_SEMI;
         default: return KIND_NAME_BYTE;
      endcase
   endfunction

   function automatic void emit_token(logic [3:0] k, logic [7:0] b);
      lex_token_type t;
      t.kind = k;
      t.text = (k == KIND_NAME_BYTE) ? b : 8'h00;
      t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void start_token(logic [7:0] b);
      logic [3:0] k;
      k = op_kind(b);
      if (is_blank(b)) begin
         lex_mode = LEX_IDLE;
      end else if (k == KIND_GT) begin
         lex_mode = LEX_GT;
      end else if (k != KIND_NAME_BYTE) begin
         lex_mode = LEX_IDLE;
         emit_token(k, 8'h00);
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         lex_mode = LEX_QUOTE;
         quote_single = (b == CH_SQUOTE);
      end else begin
         lex_mode = LEX_NAME;
         emit_token(KIND_NAME_BYTE, b);
      end
   endfunction

   function automatic void predict_tokens(logic op, logic [7:0] b);
      step_tokens.delete();
      if (op == OP_EOL) begin
         if (lex_mode == LEX_NAME || lex_mode == LEX_QUOTE) begin
            emit_token(KIND_NAME_END, 8'h00);
         end else if (lex_mode == LEX_GT) begin
            emit_token(KIND_GT, 8'h00);
         end
         emit_token(KIND_EOF, 8'h00);
         lex_mode = LEX_IDLE;
      end else begin
         case (lex_mode)
            LEX_IDLE: start_token(b);
            LEX_NAME: begin
               if (is_blank(b) || op_kind(b) != KIND_NAME_BYTE) begin
                  emit_token(KIND_NAME_END, 8'h00);
                  start_token(b);
               end else begin
                  emit_token(KIND_NAME_BYTE, b);
               end
            end
            LEX_QUOTE: begin
               if (b == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                  emit_token(KIND_NAME_END, 8'h00);
                  lex_mode = LEX_IDLE;
               end else begin
                  emit_token(KIND_NAME_BYTE, b);
               end
            end
            default: begin
               if (b == CH_GT) begin
                  emit_token(KIND_APPEND, 8'h00);
                  lex_mode = LEX_IDLE;
               end else begin
                  emit_token(KIND_GT, 8'h00);
                  start_token(b);
               end
            end
         endcase
      end
      if (step_tokens.size() > 0) begin
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      lex_token_type t;
      if (!reset) begin
         if (push && !full) begin
            predict_tokens(req_opcode, req_char_byte);
            if (fixed_on && fixed_row.fixed) begin
               if (fixed_row.count > 0) begin
                  t.kind = fixed_row.k0;
                  t.text = fixed_row.x0;
                  t.last = (fixed_row.count == 2'd1);
                  pending_tokens.push_back(t);
               end
               if (fixed_row.count > 1) begin
                  t.kind = fixed_row.k1;
                  t.text = fixed_row.x1;
                  t.last = 1'b1;
                  pending_tokens.push_back(t);
               end
            end else begin
               foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
            end
            items_accepted++;
            if (req_opcode == OP_EOL) eol_accepted++;
         end
         if (pop && !empty) begin
            if (pending_tokens.size() == 0) begin
               $error("unexpected token: kind %0d text %0d last %0d",
                      rsp_token_kind, rsp_text_byte, rsp_last_of_run);
               fail_count++;
            end else begin
               t = pending_tokens.pop_front();
               if (rsp_token_kind !== t.kind) begin
                  $error("token_kind: expected %0d, actual %0d", t.kind, rsp_token_kind);
                  fail_count++;
               end
               if (rsp_text_byte !== t.text) begin
                  $error("text_byte: expected %0d, actual %0d", t.text, rsp_text_byte);
                  fail_count++;
               end
               if (rsp_last_of_run !== t.last) begin
                  $error("last_of_run: expected %0d, actual %0d", t.last, rsp_last_of_run);
                  fail_count++;
               end
            end
            tokens_seen++;
            if (rsp_token_kind >= KIND_PIPE && rsp_token_kind <= KIND_SEMI) operators_seen++;
         end
      end
   end

   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_request(input logic op, input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_char_byte <= ch;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_char(input logic [7:0] b);
      send_request(OP_CHAR, b);
   endtask

   function automatic logic [7:0] rand_blank();
      logic [7:0] b;
      b = 8'($urandom_range(9, 14));
      return (b == 8'd14) ? CH_SPACE : b;
   endfunction

   function automatic logic [7:0] rand_name_char(logic allow_quote);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (is_blank(b) || op_kind(b) != KIND_NAME_BYTE
             || b == CH_DQUOTE || b == CH_SQUOTE) begin
         b = 8'($urandom_range(255));
      end
      if (allow_quote && $urandom_range(9) == 0) b = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      return b;
   endfunction

   task automatic send_command_line();
      int ntok;
      int len;
      logic [7:0] q;
      logic [7:0] b;
      logic [7:0] ops [0:4];
      ops = '{CH_PIPE, CH_AMP, CH_LT, CH_GT, CH_SEMI};
      ntok = $urandom_range(1, 7);
      for (int i = 0; i < ntok; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               len = $urandom_range(1, 6);
               for (int j = 0; j < len; j++) send_char(rand_name_char(j > 0));
            end
            4, 5: begin
               q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
               send_char(q);
               len = $urandom_range(0, 5);
               for (int j = 0; j < len; j++) begin
                  b = 8'($urandom_range(255));
                  if (b == q || $urandom_range(7) == 0) begin
                     b = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
                  end
                  send_char(b);
               end
               if (!(i == ntok - 1 && $urandom_range(3) == 0)) send_char(q);
            end
            6, 7: begin
               if ($urandom_range(5) == 0) begin
                  send_char(CH_GT);
                  send_char(CH_GT);
               end else begin
                  send_char(ops[3'($urandom_range(4))]);
               end
            end
            8: begin
               len = $urandom_range(1, 3);
               for (int j = 0; j < len; j++) send_char(rand_blank());
            end
            default: begin
               send_char(CH_GT);
               send_char(8'($urandom_range(255)));
            end
         endcase
         if ($urandom_range(1)) send_char(rand_blank());
      end
      send_request(OP_EOL, 8'($urandom_range(255)));
   endtask

   task automatic send_random_until(input int target);
      int len;
      while (items_sent < target) begin
         if ($urandom_range(4) == 0) begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++) send_char(8'($urandom_range(255)));
            if ($urandom_range(1)) send_request(OP_EOL, 8'($urandom_range(255)));
         end else begin
            send_command_line();
         end
      end
   endtask

   initial begin
      push = 1'b0;
      req_opcode = OP_CHAR;
      req_char_byte = 8'h00;
      reset = 1'b1;
      directed_rows = '{
         '{OP_EOL,    8'hA5,     1'b1, 2'd1, KIND_EOF,       8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'h61,     1'b1, 2'd1, KIND_NAME_BYTE, 8'h61, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'h00,     1'b1, 2'd1, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'hFF,     1'b1, 2'd1, KIND_NAME_BYTE, 8'hFF, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_DQUOTE, 1'b1, 2'd1, KIND_NAME_BYTE, 8'h22, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_SPACE,  1'b1, 2'd1, KIND_NAME_END,  8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_TAB,    1'b1, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_SQUOTE, 1'b1, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_DQUOTE, 1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'h80,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_SQUOTE, 1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'h78,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_PIPE,   1'b1, 2'd2, KIND_NAME_END,  8'h00, KIND_PIPE,      8'h00},
         '{OP_CHAR,   CH_AMP,    1'b1, 2'd1, KIND_AMP,       8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_LT,     1'b1, 2'd1, KIND_LT,        8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_SEMI,   1'b1, 2'd1, KIND_SEMI,      8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_GT,     1'b1, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_GT,     1'b1, 2'd1, KIND_APPEND,    8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_GT,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'h62,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_CR,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   CH_DQUOTE, 1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_CHAR,   8'h71,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_EOL,    8'h5A,     1'b1, 2'd2, KIND_NAME_END,  8'h00, KIND_EOF,       8'h00},
         '{OP_CHAR,   CH_GT,     1'b0, 2'd0, KIND_NAME_BYTE, 8'h00, KIND_NAME_BYTE, 8'h00},
         '{OP_EOL,    8'hFF,     1'b1, 2'd2, KIND_GT,        8'h00, KIND_EOF,       8'h00}
      };
      send_idle_pct = 13;
      recv_idle_pct = 81;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      fixed_on = 1'b1;
      foreach (directed_rows[i]) begin
         fixed_row = directed_rows[i];
         send_request(directed_rows[i].op, directed_rows[i].ch);
      end
      fixed_on = 1'b0;

      send_random_until(items_sent + 600);
      send_idle_pct = 81;
      recv_idle_pct = 13;
      send_random_until(items_sent + 600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = HOLD_CYCLES;
      send_random_until(ITEM_TARGET);
      push <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_tokens.size() != 0) begin
         $error("%0d expected tokens never arrived", pending_tokens.size());
         fail_count++;
      end

      $display("Lexed %0d requests, %0d of them end-of-line, under three idle mixes.",
               items_accepted, eol_accepted);
      $display("Checked %0d tokens, %0d operators, with a long output stall.",
               tokens_seen, operators_seen);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
